// ===== sv/hbfa_pkg.sv =====
// hbfa_pkg: types, constants and command/status structs of the harmonic bond
// force accumulator; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hbfa_pkg;

  localparam int IdxW   = 10;
  localparam int PosW   = 32;
  localparam int AccW   = 48;
  localparam int CfgW   = 32;
  localparam int EntryW = 3 * AccW + 1;

  localparam logic [AccW-1:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [AccW-1:0] ACC_MIN = 48'h8000_0000_0000;

  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_READ       = 1'b1;

  localparam logic REG_SPRING = 1'b0;
  localparam logic REG_REST   = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic [IdxW-1:0]        first_index;
    logic [IdxW-1:0]        second_index;
    logic signed [PosW-1:0] first_pos_x;
    logic signed [PosW-1:0] first_pos_y;
    logic signed [PosW-1:0] first_pos_z;
    logic signed [PosW-1:0] second_pos_x;
    logic signed [PosW-1:0] second_pos_y;
    logic signed [PosW-1:0] second_pos_z;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0]        read_index;
    logic signed [AccW-1:0] force_x;
    logic signed [AccW-1:0] force_y;
    logic signed [AccW-1:0] force_z;
    logic                   saturated;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SQ, ST_SQRT, ST_DISP, ST_MULA, ST_CAPA, ST_NUM,
    ST_DIVI, ST_DIV, ST_FORCE, ST_RD1, ST_WR1, ST_RD2, ST_WR2, ST_RDR
  } state_e;

  typedef struct packed {
    logic       load;
    logic       sq_mul;
    logic       sq_acc;
    logic       sqrt_step;
    logic       disp_en;
    logic       mula;
    logic       capa;
    logic       num_mul;
    logic       num_acc;
    logic       div_init;
    logic       div_step;
    logic       force_en;
    logic       rd1;
    logic       wr1;
    logic       rd2;
    logic       wr2;
    logic       rdr;
    logic       outr;
    logic       clr_step;
    logic [1:0] mul_lane;
    logic       mul_hi;
    logic [1:0] acc_lane;
    logic       acc_hi;
  } cmd_t;

  typedef struct packed {
    logic in_read;
    logic in_ok1;
    logic in_ok2;
    logic root_zero;
    logic clr_last;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/hbfa_ram.sv =====
// hbfa_ram: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module hbfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ===== sv/hbfa_ctrl.sv =====
// hbfa_ctrl: sequencer of the bond force accumulator
// depends on hbfa_pkg
`timescale 1ns / 1ps
`default_nettype none
module hbfa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire hbfa_pkg::status_t status_i,
  output hbfa_pkg::cmd_t         cmd_o
);
  import hbfa_pkg::*;

  localparam logic [5:0] SqLast   = 6'd3;
  localparam logic [5:0] SqrtLast = 6'd33;
  localparam logic [5:0] NumMuls  = 6'd6;
  localparam logic [5:0] DivLast  = 6'd47;

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [5:0] prev_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cmd_o    = '0;
    busy_o   = (state_q != ST_IDLE);
    prev_cnt = cnt_q - 6'd1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          if (status_i.in_read) begin
            state_d = ST_RDR;
          end else if (status_i.in_ok1 && status_i.in_ok2) begin
            state_d = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        if (cnt_q < SqLast) begin
          cmd_o.sq_mul   = 1'b1;
          cmd_o.mul_lane = cnt_q[1:0];
        end
        if (cnt_q != '0) begin
          cmd_o.sq_acc = 1'b1;
        end
        if (cnt_q == SqLast) begin
          cnt_d   = '0;
          state_d = ST_SQRT;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == SqrtLast) begin
          cnt_d   = '0;
          state_d = ST_DISP;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_DISP: begin
        cmd_o.disp_en = 1'b1;
        state_d = status_i.root_zero ? ST_IDLE : ST_MULA;
      end
      ST_MULA: begin
        cmd_o.mula = 1'b1;
        state_d = ST_CAPA;
      end
      ST_CAPA: begin
        cmd_o.capa = 1'b1;
        cnt_d   = '0;
        state_d = ST_NUM;
      end
      ST_NUM: begin
        if (cnt_q < NumMuls) begin
          cmd_o.num_mul  = 1'b1;
          cmd_o.mul_lane = cnt_q[2:1];
          cmd_o.mul_hi   = cnt_q[0];
        end
        if (cnt_q != '0) begin
          cmd_o.num_acc  = 1'b1;
          cmd_o.acc_lane = prev_cnt[2:1];
          cmd_o.acc_hi   = prev_cnt[0];
        end
        if (cnt_q == NumMuls) begin
          cnt_d   = '0;
          state_d = ST_DIVI;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DivLast) begin
          cnt_d   = '0;
          state_d = ST_FORCE;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_FORCE: begin
        cmd_o.force_en = 1'b1;
        state_d = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rd1 = 1'b1;
        state_d = ST_WR1;
      end
      ST_WR1: begin
        cmd_o.wr1 = 1'b1;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd2 = 1'b1;
        state_d = ST_WR2;
      end
      ST_WR2: begin
        cmd_o.wr2 = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RDR: begin
        cmd_o.rdr = 1'b1;
        cnt_d   = '1;
        state_d = ST_RDR;
        if (cnt_q == '1) begin
          cmd_o.rdr  = 1'b0;
          cmd_o.outr = 1'b1;
          cnt_d      = '0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_clear_blocks_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_step |-> !cmd_o.load)
    else $error("item accepted during clearing pass");
  a_force_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.force_en |-> $past(cmd_o.div_step))
    else $error("force formed before division finished");
  a_wr2_after_rd2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr2 |-> $past(cmd_o.rd2))
    else $error("second write without read");
`endif

endmodule
`default_nettype wire

// ===== sv/hbfa_datapath.sv =====
// hbfa_datapath: difference vector, shared multiplier, square root, three
// division lanes and the force accumulator ram; depends on hbfa_pkg, hbfa_ram
`timescale 1ns / 1ps
`default_nettype none
module hbfa_datapath #(
  parameter int MAX_PARTICLES = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hbfa_pkg::in_word_t           in_word_i,
  input  wire logic [hbfa_pkg::CfgW-1:0]    spring_constant_i,
  input  wire logic [hbfa_pkg::CfgW-1:0]    rest_length_i,
  input  wire hbfa_pkg::cmd_t               cmd_i,
  output hbfa_pkg::status_t                 status_o,
  output hbfa_pkg::result_t                 result_o,
  output logic                              result_strobe_o
);
  import hbfa_pkg::*;

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  function automatic logic [AccW:0] sat_add(input logic [AccW-1:0] a,
                                            input logic [AccW-1:0] b);
    logic [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) begin
      return {1'b1, (s[AccW] ? ACC_MIN : ACC_MAX)};
    end
    return {1'b0, s[AccW-1:0]};
  endfunction

  logic [IdxW-1:0] i1_q, i2_q;
  logic            ok1_q;
  logic [32:0]     dmag_q [3];
  logic            dneg_q [3];
  logic [67:0]     sum_q;
  logic [33:0]     root_q;
  logic [35:0]     rem_q;
  logic [33:0]     dispmag_q;
  logic            dispneg_q;
  logic [67:0]     prod_q;
  logic [65:0]     a_q;
  logic [98:0]     num_q [3];
  logic [50:0]     drem_q [3];
  logic [47:0]     quo_q [3];
  logic            over_q [3];
  logic [47:0]     f_q [3];
  logic            fclamp_q;
  logic [AW-1:0]   clr_q;
  result_t         res_q;
  logic            strobe_q;

  logic [31:0]     fp [3];
  logic [31:0]     sp [3];
  logic [32:0]     diff [3];
  logic [33:0]     opa, opb;
  logic [37:0]     remsh, trial;
  logic [34:0]     disp;
  logic [49:0]     divisor;
  logic [50:0]     dsh [3];
  logic [47:0]     fmag [3];
  logic            fclamp_any;
  logic [47:0]     fadd [3];
  logic [48:0]     acc [3];
  logic [EntryW-1:0] rdata, wdata, upd;
  logic [AW-1:0]   addr;
  logic            we;

  assign fp[0] = in_word_i.first_pos_x;
  assign fp[1] = in_word_i.first_pos_y;
  assign fp[2] = in_word_i.first_pos_z;
  assign sp[0] = in_word_i.second_pos_x;
  assign sp[1] = in_word_i.second_pos_y;
  assign sp[2] = in_word_i.second_pos_z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = {sp[c][31], sp[c]} - {fp[c][31], fp[c]};
    end
  end

  // shared multiplier operand select
  always_comb begin
    opa = '0;
    opb = '0;
    if (cmd_i.sq_mul) begin
      opa = {1'b0, dmag_q[cmd_i.mul_lane]};
      opb = {1'b0, dmag_q[cmd_i.mul_lane]};
    end else if (cmd_i.mula) begin
      opa = {2'b00, spring_constant_i};
      opb = dispmag_q;
    end else if (cmd_i.num_mul) begin
      opa = cmd_i.mul_hi ? {2'b00, a_q[65:34]} : a_q[33:0];
      opb = {1'b0, dmag_q[cmd_i.mul_lane]};
    end
  end

  assign remsh   = {rem_q, sum_q[67:66]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign disp    = {1'b0, root_q} - {3'b000, rest_length_i};
  assign divisor = {root_q, 16'h0000};

  always_comb begin
    fclamp_any = 1'b0;
    for (int c = 0; c < 3; c++) begin
      dsh[c]  = {drem_q[c][49:0], num_q[c][47]};
      fmag[c] = (over_q[c] || quo_q[c][47]) ? ACC_MAX : quo_q[c];
      fclamp_any = fclamp_any | over_q[c] | quo_q[c][47];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    if (cmd_i.load) begin
      i1_q  <= in_word_i.first_index;
      i2_q  <= in_word_i.second_index;
      ok1_q <= status_o.in_ok1;
      sum_q  <= '0;
      root_q <= '0;
      rem_q  <= '0;
      for (int c = 0; c < 3; c++) begin
        dneg_q[c] <= diff[c][32];
        dmag_q[c] <= diff[c][32] ? (33'd0 - diff[c]) : diff[c];
      end
    end
    if (cmd_i.sq_acc) begin
      sum_q <= sum_q + prod_q;
    end
    if (cmd_i.sqrt_step) begin
      sum_q <= {sum_q[65:0], 2'b00};
      if (remsh >= trial) begin
        rem_q  <= 36'(remsh - trial);
        root_q <= {root_q[32:0], 1'b1};
      end else begin
        rem_q  <= remsh[35:0];
        root_q <= {root_q[32:0], 1'b0};
      end
    end
    if (cmd_i.disp_en) begin
      dispneg_q <= disp[34];
      dispmag_q <= disp[34] ? 34'(35'd0 - disp) : disp[33:0];
    end
    if (cmd_i.capa) begin
      a_q <= prod_q[65:0];
    end
    if (cmd_i.num_acc) begin
      if (cmd_i.acc_hi) begin
        num_q[cmd_i.acc_lane] <= num_q[cmd_i.acc_lane] + {prod_q[64:0], 34'h0};
      end else begin
        num_q[cmd_i.acc_lane] <= 99'(prod_q);
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.div_init) begin
        drem_q[c] <= num_q[c][98:48];
        over_q[c] <= (num_q[c][98:48] >= {1'b0, divisor});
        quo_q[c]  <= '0;
      end
      if (cmd_i.div_step) begin
        num_q[c][47:0] <= {num_q[c][46:0], 1'b0};
        if (dsh[c] >= {1'b0, divisor}) begin
          drem_q[c] <= dsh[c] - {1'b0, divisor};
          quo_q[c]  <= {quo_q[c][46:0], 1'b1};
        end else begin
          drem_q[c] <= dsh[c];
          quo_q[c]  <= {quo_q[c][46:0], 1'b0};
        end
      end
      if (cmd_i.force_en) begin
        f_q[c] <= (dispneg_q ^ dneg_q[c]) ? (48'd0 - fmag[c]) : fmag[c];
      end
    end
    if (cmd_i.force_en) begin
      fclamp_q <= fclamp_any;
    end
    if (cmd_i.outr) begin
      res_q.read_index <= i1_q;
      res_q.force_x   <= ok1_q ? rdata[47:0]   : '0;
      res_q.force_y   <= ok1_q ? rdata[95:48]  : '0;
      res_q.force_z   <= ok1_q ? rdata[143:96] : '0;
      res_q.saturated <= ok1_q ? rdata[144]    : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.outr;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // read-modify-write of one entry
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fadd[c] = cmd_i.wr1 ? (48'd0 - f_q[c]) : f_q[c];
      acc[c]  = sat_add(rdata[c*AccW +: AccW], fadd[c]);
    end
    upd = {rdata[144] | fclamp_q | acc[0][48] | acc[1][48] | acc[2][48],
           acc[2][47:0], acc[1][47:0], acc[0][47:0]};
    if (cmd_i.clr_step || cmd_i.outr) begin
      wdata = '0;
    end else begin
      wdata = upd;
    end
    if (cmd_i.clr_step) begin
      addr = clr_q;
    end else if (cmd_i.rd2 || cmd_i.wr2) begin
      addr = AW'(i2_q);
    end else begin
      addr = AW'(i1_q);
    end
    we = cmd_i.clr_step | cmd_i.wr1 | cmd_i.wr2 | (cmd_i.outr & ok1_q);
  end

  hbfa_ram #(
    .Width(EntryW),
    .Depth(MAX_PARTICLES)
  ) u_force_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign status_o.in_read   = (in_word_i.opcode == OP_READ);
  assign status_o.in_ok1    = (32'(in_word_i.first_index) < 32'(MAX_PARTICLES));
  assign status_o.in_ok2    = (32'(in_word_i.second_index) < 32'(MAX_PARTICLES));
  assign status_o.root_zero = (root_q == '0);
  assign status_o.clr_last  = (clr_q == AW'(MAX_PARTICLES - 1));

  assign result_o        = res_q;
  assign result_strobe_o = strobe_q;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (root_q != '0))
    else $error("division by zero length");
  a_no_write_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !we)
    else $error("ram written while a word is taken");
  a_strobe_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |=> !strobe_q)
    else $error("result strobe longer than one cycle");
`endif

endmodule
`default_nettype wire

// ===== sv/harmonic_bond_force_accumulator_unit.sv =====
// harmonic_bond_force_accumulator_unit: top level with apb register file
// depends on hbfa_pkg, hbfa_ctrl, hbfa_datapath
`timescale 1ns / 1ps
`default_nettype none
// Use: drive a word on in_word_i and raise start; it is taken when busy is low.
// A bond word (opcode 0) forms d = second - first, r = isqrt(|d|^2) and
// F = k*(r-r0)*d/r, subtracts F from the first particle's accumulators and adds
// it to the second's, all saturating. While busy is high it runs in order:
// the squares on the shared multiplier, the square root (one root bit a cycle),
// the displacement and the force products, the division setup, the three
// parallel restoring division lanes (one quotient bit a cycle), the force
// sign and the two ram updates.
// A bond with an index out of range is dropped and does not raise busy;
// one of zero length ends after the square root.
// A read word (opcode 1) keeps busy high while its entry is read; its result is
// registered and appears on result_o with result_strobe_o high for one cycle,
// and the entry is cleared. The receiver cannot stall.
// Registers: spring_constant at 0x0, rest_length at 0x4, to be written over apb
// while idle by the user (not enforced). After reset a clearing pass zeroes the
// accumulator ram, with busy high; register writes are taken as ever.
module harmonic_bond_force_accumulator_unit #(
  parameter int MAX_PARTICLES = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire hbfa_pkg::in_word_t        in_word_i,
  output logic                           result_strobe_o,
  output hbfa_pkg::result_t              result_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [hbfa_pkg::CfgW-1:0] pwdata,
  output logic      [hbfa_pkg::CfgW-1:0] prdata,
  output logic                           pready
);
  import hbfa_pkg::*;

  logic [CfgW-1:0] spring_q, rest_q;
  logic            cfg_we;
  cmd_t            cmd;
  status_t         status;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_q <= 32'h0001_0000;
      rest_q   <= 32'h0001_0000;
    end else if (cfg_we) begin
      if (paddr[2] == REG_REST) begin
        rest_q <= pwdata;
      end else begin
        spring_q <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_SPRING) ? spring_q : rest_q;

  hbfa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .status_i(status),
    .cmd_o   (cmd)
  );

  hbfa_datapath #(
    .MAX_PARTICLES(MAX_PARTICLES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_word_i        (in_word_i),
    .spring_constant_i(spring_q),
    .rest_length_i    (rest_q),
    .cmd_i            (cmd),
    .status_o         (status),
    .result_o         (result_o),
    .result_strobe_o  (result_strobe_o)
  );

endmodule
`default_nettype wire
